// ===== rtl/frac_pkg.sv =====
// Shared types, widths and codes of the fraction arithmetic reducer.
package frac_pkg;
   localparam int WIDTH = 32;
   localparam int DW    = 2 * WIDTH;
   localparam int CW    = $clog2(DW + 1);
   localparam int REQ_DATA_W = ((4 * WIDTH + 7) / 8) * 8;
   localparam int RSP_BITS   = 3 * WIDTH + 3;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [1:0] KIND_ADD = 2'd0;
   localparam logic [1:0] KIND_SUB = 2'd1;
   localparam logic [1:0] KIND_MUL = 2'd2;
   localparam logic [1:0] KIND_DIV = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   localparam logic ENG_GCD = 1'b0;
   localparam logic ENG_DIV = 1'b1;

   typedef struct packed {
      logic          start;
      logic          op;
      logic [DW-1:0] x;
      logic [DW-1:0] y;
   } eng_cmd_type;

   typedef struct packed {
      logic          done;
      logic [DW-1:0] value;
   } eng_rsp_type;
endpackage

// ===== rtl/frac_engine.sv =====
// Shared subtract-and-shift unit: binary GCD or restoring division, one step a cycle.
module frac_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  frac_pkg::eng_cmd_type cmd,
   output frac_pkg::eng_rsp_type rsp
);
   import frac_pkg::*;

   logic          busy_ff, busy_in;
   logic          mode_ff, mode_in;
   logic [DW-1:0] a_ff, a_in;
   logic [DW-1:0] b_ff, b_in;
   logic [DW-1:0] d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [DW-1:0] res_ff, res_in;
   logic [DW:0]   rem_sh;
   logic [DW:0]   diff;

   always_comb begin
      busy_in = busy_ff;
      mode_in = mode_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      rem_sh  = {a_ff, b_ff[DW-1]};
      diff    = rem_sh - {1'b0, d_ff};
      if (cmd.start) begin
         busy_in = 1'b1;
         mode_in = cmd.op;
         if (cmd.op == ENG_GCD) begin
            a_in   = cmd.x;
            b_in   = cmd.y;
            cnt_in = '0;
         end else begin
            a_in   = '0;
            b_in   = cmd.x;
            d_in   = cmd.y;
            cnt_in = CW'(DW);
         end
      end else if (busy_ff) begin
         if (mode_ff == ENG_GCD) begin
            priority if (a_ff == '0) begin
               res_in  = b_ff << cnt_ff;
               done_in = 1'b1;
               busy_in = 1'b0;
            end else if (b_ff == '0) begin
               res_in  = a_ff << cnt_ff;
               done_in = 1'b1;
               busy_in = 1'b0;
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_in   = a_ff >> 1;
               b_in   = b_ff >> 1;
               cnt_in = cnt_ff + 1'b1;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (a_ff >= b_ff) begin
               a_in = a_ff - b_ff;
            end else begin
               b_in = b_ff - a_ff;
            end
         end else begin
            if (!diff[DW]) begin
               a_in = diff[DW-1:0];
               b_in = {b_ff[DW-2:0], 1'b1};
            end else begin
               a_in = rem_sh[DW-1:0];
               b_in = {b_ff[DW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               res_in  = b_in;
               done_in = 1'b1;
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mode_ff <= mode_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      d_ff    <= d_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = res_ff;
endmodule

// ===== rtl/fraction_arithmetic_reducer.sv =====
// Top level of the fraction arithmetic reducer: sequencer, multiplier and result register.
//
// Use: present two signed fractions on the req_ stream (kind in req_tuser, four
// operands packed in req_tdata); one result beat per request leaves on rsp_.
// The block takes one request at a time and drops req_tready while it works.
// Latency is data dependent: a 64-bit binary GCD runs one subtract or shift
// step a cycle (a shift halves the product of the operands and a subtract is
// always followed by a shift); each exact division also runs in the shared
// engine. Multiply and divide need one GCD, two products and two divisions;
// add and subtract add a 32-bit GCD and two more divisions, and form three
// products and a sum instead. A zero denominator skips to the final check.
// The single multiplier is used for one product a cycle.
// Reset (synchronous, active high) returns the sequencer to idle and empties
// the result register. The result register holds its beat while rsp_tready
// is low; the next request is accepted meanwhile and its result waits until
// the held beat is taken.
module fraction_arithmetic_reducer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // num_a [31:0], den_a [63:32], num_b [95:64], den_b [127:96]
   input  logic [frac_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind [1:0]
   input  logic [1:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // quotient [31:0], negative [32], num_mag [64:33], den_mag [96:65],
   // status [98:97], zero fill above
   output logic [frac_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // is_integer [0]
   output logic                           rsp_tuser
);
   import frac_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_G1   = 4'd1;
   localparam logic [3:0] S_DB   = 4'd2;
   localparam logic [3:0] S_DD   = 4'd3;
   localparam logic [3:0] S_M1   = 4'd4;
   localparam logic [3:0] S_M2   = 4'd5;
   localparam logic [3:0] S_M3   = 4'd6;
   localparam logic [3:0] S_ADD  = 4'd7;
   localparam logic [3:0] S_P1   = 4'd8;
   localparam logic [3:0] S_P2   = 4'd9;
   localparam logic [3:0] S_G2   = 4'd10;
   localparam logic [3:0] S_DN   = 4'd11;
   localparam logic [3:0] S_DM   = 4'd12;
   localparam logic [3:0] S_CHK  = 4'd13;

   localparam logic [DW-1:0] LIMIT = DW'(1) << (WIDTH - 1);

   logic [3:0]       state_ff, state_in;
   logic             issued_ff, issued_in;
   logic [1:0]       kind_ff, kind_in;
   logic [WIDTH-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [WIDTH-1:0] qb_ff, qb_in, qd_ff, qd_in;
   logic             na_ff, na_in, nc_ff, nc_in, nneg_ff, nneg_in, zden_ff, zden_in;
   logic [DW-1:0]    nm_ff, nm_in, dm_ff, dm_in, ta_ff, ta_in, t_ff, t_in;

   logic             out_valid_ff, out_valid_in;
   logic             o_int_ff, o_int_in, o_neg_ff, o_neg_in;
   logic [WIDTH-1:0] o_quo_ff, o_quo_in, o_num_ff, o_num_in, o_den_ff, o_den_in;
   logic [1:0]       o_st_ff, o_st_in;

   logic [WIDTH-1:0] mul_x, mul_y;
   logic [DW-1:0]    prod;
   eng_cmd_type      cmd;
   eng_rsp_type      ersp;

   logic [WIDTH-1:0] in_v [4];
   logic [WIDTH-1:0] in_m [4];
   logic             in_s [4];
   logic             fin_neg, fin_ovf, fin_int, out_free;

   frac_engine u_engine (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rsp   (ersp)
   );

   assign prod = DW'(mul_x) * DW'(mul_y);

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         in_v[i] = req_tdata[i*WIDTH +: WIDTH];
         in_s[i] = in_v[i][WIDTH-1];
         in_m[i] = in_s[i] ? (~in_v[i] + 1'b1) : in_v[i];
      end
   end

   // Final range check on the reduced fraction
   always_comb begin
      fin_neg = nneg_ff && (nm_ff != '0);
      fin_int = (dm_ff == DW'(1));
      if (fin_int) begin
         fin_ovf = fin_neg ? (nm_ff > LIMIT) : (nm_ff >= LIMIT);
      end else begin
         fin_ovf = (nm_ff > LIMIT) || (dm_ff > LIMIT);
      end
   end

   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      kind_in      = kind_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      qb_in = qb_ff; qd_in = qd_ff;
      na_in = na_ff; nc_in = nc_ff; nneg_in = nneg_ff; zden_in = zden_ff;
      nm_in = nm_ff; dm_in = dm_ff; ta_in = ta_ff; t_in = t_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      o_int_in = o_int_ff; o_neg_in = o_neg_ff; o_quo_in = o_quo_ff;
      o_num_in = o_num_ff; o_den_in = o_den_ff; o_st_in = o_st_ff;
      mul_x     = a_ff;
      mul_y     = c_ff;
      cmd.start = 1'b0;
      cmd.op    = ENG_GCD;
      cmd.x     = nm_ff;
      cmd.y     = dm_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in = req_tuser;
               a_in = in_m[0]; b_in = in_m[1]; c_in = in_m[2]; d_in = in_m[3];
               na_in   = in_s[0] ^ in_s[1];
               nc_in   = in_s[2] ^ in_s[3] ^ (req_tuser == KIND_SUB);
               nneg_in = in_s[0] ^ in_s[1] ^ in_s[2] ^ in_s[3];
               zden_in = (in_m[1] == '0) || (in_m[3] == '0) ||
                         ((req_tuser == KIND_DIV) && (in_m[2] == '0));
               issued_in = 1'b0;
               priority if (zden_in) begin
                  state_in = S_CHK;
               end else if (req_tuser == KIND_ADD || req_tuser == KIND_SUB) begin
                  state_in = S_G1;
               end else begin
                  state_in = S_P1;
               end
            end
         end
         S_G1: begin
            cmd.op = ENG_GCD;
            cmd.x  = DW'(b_ff);
            cmd.y  = DW'(d_ff);
            if (!issued_ff) begin
               cmd.start = 1'b1;
               issued_in = 1'b1;
            end else if (ersp.done) begin
               t_in      = ersp.value;
               issued_in = 1'b0;
               state_in  = S_DB;
            end
         end
         S_DB: begin
            cmd.op = ENG_DIV;
            cmd.x  = DW'(b_ff);
            cmd.y  = t_ff;
            if (!issued_ff) begin
               cmd.start = 1'b1;
               issued_in = 1'b1;
            end else if (ersp.done) begin
               qb_in     = ersp.value[WIDTH-1:0];
               issued_in = 1'b0;
               state_in  = S_DD;
            end
         end
         S_DD: begin
            cmd.op = ENG_DIV;
            cmd.x  = DW'(d_ff);
            cmd.y  = t_ff;
            if (!issued_ff) begin
               cmd.start = 1'b1;
               issued_in = 1'b1;
            end else if (ersp.done) begin
               qd_in     = ersp.value[WIDTH-1:0];
               issued_in = 1'b0;
               state_in  = S_M1;
            end
         end
         S_M1: begin
            // common denominator: (b / g) * d
            mul_x    = qb_ff;
            mul_y    = d_ff;
            dm_in    = prod;
            state_in = S_M2;
         end
         S_M2: begin
            mul_x    = a_ff;
            mul_y    = qd_ff;
            ta_in    = prod;
            state_in = S_M3;
         end
         S_M3: begin
            mul_x    = c_ff;
            mul_y    = qb_ff;
            t_in     = prod;
            state_in = S_ADD;
         end
         S_ADD: begin
            priority if (na_ff == nc_ff) begin
               nm_in   = ta_ff + t_ff;
               nneg_in = na_ff;
            end else if (ta_ff >= t_ff) begin
               nm_in   = ta_ff - t_ff;
               nneg_in = na_ff;
            end else begin
               nm_in   = t_ff - ta_ff;
               nneg_in = nc_ff;
            end
            state_in = S_G2;
         end
         S_P1: begin
            mul_x    = a_ff;
            mul_y    = (kind_ff == KIND_MUL) ? c_ff : d_ff;
            nm_in    = prod;
            state_in = S_P2;
         end
         S_P2: begin
            mul_x    = b_ff;
            mul_y    = (kind_ff == KIND_MUL) ? d_ff : c_ff;
            dm_in    = prod;
            state_in = S_G2;
         end
         S_G2: begin
            cmd.op = ENG_GCD;
            cmd.x  = nm_ff;
            cmd.y  = dm_ff;
            if (!issued_ff) begin
               cmd.start = 1'b1;
               issued_in = 1'b1;
            end else if (ersp.done) begin
               t_in      = ersp.value;
               issued_in = 1'b0;
               state_in  = S_DN;
            end
         end
         S_DN: begin
            cmd.op = ENG_DIV;
            cmd.x  = nm_ff;
            cmd.y  = t_ff;
            if (!issued_ff) begin
               cmd.start = 1'b1;
               issued_in = 1'b1;
            end else if (ersp.done) begin
               nm_in     = ersp.value;
               issued_in = 1'b0;
               state_in  = S_DM;
            end
         end
         S_DM: begin
            cmd.op = ENG_DIV;
            cmd.x  = dm_ff;
            cmd.y  = t_ff;
            if (!issued_ff) begin
               cmd.start = 1'b1;
               issued_in = 1'b1;
            end else if (ersp.done) begin
               dm_in     = ersp.value;
               issued_in = 1'b0;
               state_in  = S_CHK;
            end
         end
         S_CHK: begin
            // hold the finished result until the output register frees up
            if (out_free) begin
               out_valid_in = 1'b1;
               o_int_in = 1'b0; o_neg_in = 1'b0; o_quo_in = '0;
               o_num_in = '0;   o_den_in = '0;
               priority if (zden_ff) begin
                  o_st_in = ST_ZERO_DEN;
               end else if (fin_ovf) begin
                  o_st_in = ST_OVERFLOW;
               end else begin
                  o_st_in  = ST_OK;
                  o_int_in = fin_int;
                  o_neg_in = fin_neg;
                  o_num_in = nm_ff[WIDTH-1:0];
                  o_den_in = dm_ff[WIDTH-1:0];
                  if (fin_int) begin
                     o_quo_in = fin_neg ? (~nm_ff[WIDTH-1:0] + 1'b1) : nm_ff[WIDTH-1:0];
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         out_valid_ff <= out_valid_in;
      end
      kind_ff <= kind_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
      qb_ff <= qb_in; qd_ff <= qd_in;
      na_ff <= na_in; nc_ff <= nc_in; nneg_ff <= nneg_in; zden_ff <= zden_in;
      nm_ff <= nm_in; dm_ff <= dm_in; ta_ff <= ta_in; t_ff <= t_in;
      o_int_ff <= o_int_in; o_neg_ff <= o_neg_in; o_quo_ff <= o_quo_in;
      o_num_ff <= o_num_in; o_den_ff <= o_den_in; o_st_ff <= o_st_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = o_int_ff;
   assign rsp_tdata  = RSP_DATA_W'({o_st_ff, o_den_ff, o_num_ff, o_neg_ff, o_quo_ff});
endmodule
